// File: rtl/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// shared constants, types and state codes of the segment descriptor decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SEL_IDX_W     = 13;
  localparam int CMP_W         = SEL_IDX_W + 1;

  localparam logic [CMP_W-1:0] ENTRIES_CMP = CMP_W'(TABLE_ENTRIES);

  localparam logic       CMD_WRITE  = 1'b0;
  localparam logic       CMD_LOOKUP = 1'b1;

  localparam logic [3:0] TYPE_LDT      = 4'h2;
  localparam logic [3:0] TYPE_TSS_AVL  = 4'h9;
  localparam logic [3:0] TYPE_TSS_BUSY = 4'hB;

  localparam logic [11:0] GRAN_FILL = 12'hFFF;
  localparam logic [16:0] AR_UNUSABLE = 17'h10000;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD0  = 4'b0010,
    S_RD1  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [63:0]      wdata;
  } ram_req_t;

endpackage

`default_nettype wire

// File: rtl/sdd_table_ram.sv
// ----------------------------------------------------------------------------
// sdd_table_ram
// descriptor table storage, one port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdd_table_ram (
  input  wire logic              clk,
  input  wire sdd_pkg::ram_req_t req,
  output logic [63:0]            rdata
);

  logic [63:0] mem [sdd_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

`default_nettype wire

// File: rtl/sdd_lookup_ctrl.sv
// ----------------------------------------------------------------------------
// sdd_lookup_ctrl
// item sequencer: table writes, selector checks, descriptor decode, result reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdd_lookup_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [15:0]       table_byte_limit,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              cmd,
  input  wire logic [5:0]        entry_index,
  input  wire logic [63:0]       entry_word,
  input  wire logic [15:0]       seg_selector,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [63:0]            seg_base,
  output logic [31:0]            seg_limit,
  output logic [16:0]            access_rights,
  output sdd_pkg::ram_req_t      ram_req,
  input  wire logic [63:0]       ram_rdata
);

  sdd_pkg::state_t state, state_next;

  logic [sdd_pkg::SEL_IDX_W-1:0] idx;
  logic [63:0]                   r_base;
  logic [31:0]                   r_limit;
  logic [16:0]                   r_ar;

  logic                          in_xfer;
  logic [sdd_pkg::SEL_IDX_W-1:0] sel_idx;
  logic                          lookup_bad;
  logic                          entry_ok;
  logic [sdd_pkg::CMP_W-1:0]     entry_ext;
  logic [sdd_pkg::CMP_W-1:0]     idx_plus1;
  logic [16:0]                   ext_end;
  logic                          ext_ok;

  logic [19:0] raw_limit;
  logic [31:0] dec_limit;
  logic [16:0] dec_ar;
  logic        sys_ext;
  logic        out_free;

  assign in_ready = (state == sdd_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // selector checks
  assign sel_idx    = seg_selector[15:3];
  assign lookup_bad = (sel_idx == '0) || seg_selector[2] ||
                      ({sel_idx, 3'b111} > table_byte_limit) ||
                      ({1'b0, sel_idx} >= sdd_pkg::ENTRIES_CMP);
  assign entry_ext  = sdd_pkg::CMP_W'(entry_index);
  assign entry_ok   = entry_ext < sdd_pkg::ENTRIES_CMP;

  // second word for system descriptors
  assign idx_plus1 = {1'b0, idx} + sdd_pkg::CMP_W'(1);
  assign ext_end   = {1'b0, idx, 3'b111} + 17'd8;
  assign ext_ok    = (ext_end <= {1'b0, table_byte_limit}) &&
                     (idx_plus1 < sdd_pkg::ENTRIES_CMP);

  // descriptor decode of the first word
  assign raw_limit = {ram_rdata[51:48], ram_rdata[15:0]};
  assign dec_limit = ram_rdata[55] ? {raw_limit, sdd_pkg::GRAN_FILL} : {12'b0, raw_limit};
  assign dec_ar    = {~ram_rdata[47], ram_rdata[55:52], 4'b0000, ram_rdata[47:40]};
  assign sys_ext   = !ram_rdata[44] &&
                     ((ram_rdata[43:40] == sdd_pkg::TYPE_LDT) ||
                      (ram_rdata[43:40] == sdd_pkg::TYPE_TSS_AVL) ||
                      (ram_rdata[43:40] == sdd_pkg::TYPE_TSS_BUSY));

  // memory port
  always_comb begin
    ram_req.we    = in_xfer && (cmd == sdd_pkg::CMD_WRITE) && entry_ok;
    ram_req.wdata = entry_word;
    if (state == sdd_pkg::S_RD0) begin
      ram_req.addr = idx_plus1[sdd_pkg::IDX_W-1:0];
    end else if (cmd == sdd_pkg::CMD_WRITE) begin
      ram_req.addr = entry_ext[sdd_pkg::IDX_W-1:0];
    end else begin
      ram_req.addr = sel_idx[sdd_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sdd_pkg::S_IDLE: begin
        if (in_xfer) begin
          if ((cmd == sdd_pkg::CMD_LOOKUP) && !lookup_bad) begin
            state_next = sdd_pkg::S_RD0;
          end else begin
            state_next = sdd_pkg::S_HOLD;
          end
        end
      end
      sdd_pkg::S_RD0: begin
        if (sys_ext && ext_ok) begin
          state_next = sdd_pkg::S_RD1;
        end else begin
          state_next = sdd_pkg::S_HOLD;
        end
      end
      sdd_pkg::S_RD1: begin
        state_next = sdd_pkg::S_HOLD;
      end
      sdd_pkg::S_HOLD: begin
        if (out_free) begin
          state_next = sdd_pkg::S_IDLE;
        end
      end
      default: state_next = sdd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdd_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == sdd_pkg::S_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      sdd_pkg::S_IDLE: begin
        idx     <= sel_idx;
        r_base  <= '0;
        r_limit <= '0;
        r_ar    <= (cmd == sdd_pkg::CMD_LOOKUP) ? sdd_pkg::AR_UNUSABLE : '0;
      end
      sdd_pkg::S_RD0: begin
        r_base  <= (sys_ext && !ext_ok) ? 64'b0 :
                   {32'b0, ram_rdata[63:56], ram_rdata[39:16]};
        r_limit <= dec_limit;
        r_ar    <= dec_ar;
      end
      sdd_pkg::S_RD1: begin
        r_base[63:32] <= ram_rdata[31:0];
      end
      sdd_pkg::S_HOLD: begin
        if (out_free) begin
          seg_base      <= r_base;
          seg_limit     <= r_limit;
          access_rights <= r_ar;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/segment_descriptor_decoder_top.sv
// ----------------------------------------------------------------------------
// segment_descriptor_decoder_top
// x86 descriptor table with selector decode into base, limit, access rights
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): cmd 0 stores entry_word at entry_index,
//   cmd 1 decodes seg_selector against the table. every transfer gives one
//   result on the output channel (out_valid/out_ready); a write returns zeros.
//   cfg_wr_en/cfg_wr_data load table_byte_limit; the user must load it
//   only while idle, the block does not check it. one item is in flight
//   at a time. the table is a single-port memory with registered read
//   data, so a write or a rejected selector goes from its transfer
//   straight to the result register, a plain descriptor first reads its
//   table word, an ldt/tss descriptor also its second word. the next
//   item is taken once the result is registered.
//   reset clears the sequencer, the output valid and table_byte_limit; table
//   contents stay undefined until written, no clearing pass.
//   a stalled receiver holds the result register; the decoded result then
//   waits in the sequencer and no new item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_descriptor_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [5:0]  entry_index,
  input  wire logic [63:0] entry_word,
  input  wire logic [15:0] seg_selector,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      seg_base,
  output logic [31:0]      seg_limit,
  output logic [16:0]      access_rights
);

  logic [15:0]       table_byte_limit;
  sdd_pkg::ram_req_t ram_req;
  logic [63:0]       ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_byte_limit <= '0;
    end else if (cfg_wr_en) begin
      table_byte_limit <= cfg_wr_data;
    end
  end

  sdd_table_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  sdd_lookup_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .table_byte_limit (table_byte_limit),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .entry_index      (entry_index),
    .entry_word       (entry_word),
    .seg_selector     (seg_selector),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .seg_base         (seg_base),
    .seg_limit        (seg_limit),
    .access_rights    (access_rights),
    .ram_req          (ram_req),
    .ram_rdata        (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/sdd_checker.sv
// ----------------------------------------------------------------------------
// sdd_checker
// port-level checks of the segment descriptor decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] seg_base,
  input wire logic [31:0] seg_limit,
  input wire logic [16:0] access_rights
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seg_base) &&
      $stable(seg_limit) && $stable(access_rights))
    else $error("result changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  // usable decoded result implies present descriptor, write results (all zero) are exempt
  a_usable_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && !access_rights[16] && (access_rights != '0) |-> access_rights[7])
    else $error("usable result without present bit");

  // page granular limit fills the low bits
  a_gran_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_rights[15] |-> seg_limit[11:0] == 12'hFFF)
    else $error("granular limit not filled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind segment_descriptor_decoder_top sdd_checker u_sdd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .seg_base      (seg_base),
  .seg_limit     (seg_limit),
  .access_rights (access_rights)
);

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the segment descriptor decoder
// ----------------------------------------------------------------------------
// a queue of table writes and selector lookups feeds a bursty valid/ready
// driver. every transfer is decoded by a local descriptor decoder into an
// expected base, limit and access-rights triple. a monitor with its own
// stall pattern checks each returned result against the oldest expectation.
// the table byte limit is changed between phases, while the block is idle,
// covering zero, the full range, exactly the table depth and odd offsets.
// lookups are only issued where every table word they decode has been
// written before.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic        cmd;
    logic [5:0]  index;
    logic [63:0] word;
    logic [15:0] sel;
    bit          drain_first;
  } seg_item_t;

  typedef struct {
    logic [63:0] base;
    logic [31:0] limit;
    logic [16:0] ar;
  } seg_result_t;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = sdd_pkg::CMD_WRITE;
  logic [5:0]  entry_index = '0;
  logic [63:0] entry_word = '0;
  logic [15:0] seg_selector = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] seg_base;
  logic [31:0] seg_limit;
  logic [16:0] access_rights;

  segment_descriptor_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .entry_word   (entry_word),
    .seg_selector (seg_selector),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seg_base     (seg_base),
    .seg_limit    (seg_limit),
    .access_rights(access_rights)
  );

  always #5 clk = ~clk;

  // decoder state: table updated on accepted transfers, limit set with the configuration
  logic [63:0] shadow_table [sdd_pkg::TABLE_ENTRIES];
  logic [15:0] shadow_limit = '0;

  // generator view of the table, used to keep lookups on written entries
  logic [63:0] gen_word [sdd_pkg::TABLE_ENTRIES];
  bit          gen_written [sdd_pkg::TABLE_ENTRIES];
  logic [15:0] gen_limit = '0;

  seg_item_t   item_q [$];
  seg_result_t expected_segments [$];

  int n_accepted = 0;
  int n_received = 0;
  int mismatch_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_left = 0;
  int rx_tick = 0;
  rx_mode_t rx_mode = RX_FREE;

  int n_writes = 0, n_lookups = 0, n_rejected = 0, n_upper = 0, n_absent = 0;
  int n_settings = 0;

  function automatic bit is_system_pair(logic [63:0] w);
    return !w[44] && (w[43:40] == sdd_pkg::TYPE_LDT ||
                      w[43:40] == sdd_pkg::TYPE_TSS_AVL ||
                      w[43:40] == sdd_pkg::TYPE_TSS_BUSY);
  endfunction

  function automatic seg_result_t decode_item(seg_item_t it);
    seg_result_t r;
    int          idx;
    int          off;
    logic [63:0] w;
    logic [31:0] lim;
    r.base  = '0;
    r.limit = '0;
    r.ar    = '0;
    if (it.cmd == sdd_pkg::CMD_WRITE) begin
      shadow_table[it.index] = it.word;
      n_writes++;
      return r;
    end
    n_lookups++;
    r.ar = sdd_pkg::AR_UNUSABLE;
    idx  = it.sel[15:3];
    off  = idx * 8;
    if (idx == 0 || it.sel[2] || off + 7 > shadow_limit ||
        idx >= sdd_pkg::TABLE_ENTRIES) begin
      n_rejected++;
      return r;
    end
    w = shadow_table[idx];
    r.base = {32'h0, w[63:56], w[39:16]};
    if (is_system_pair(w)) begin
      if (off + 15 > shadow_limit || idx + 1 >= sdd_pkg::TABLE_ENTRIES) begin
        r.base = '0;
      end else begin
        r.base[63:32] = shadow_table[idx + 1][31:0];
        n_upper++;
      end
    end
    lim = {12'h0, w[51:48], w[15:0]};
    if (w[55]) begin
      lim = {lim[19:0], sdd_pkg::GRAN_FILL};
    end
    r.limit = lim;
    r.ar = {~w[47], w[55:52], 4'h0, w[47:40]};
    if (!w[47]) begin
      n_absent++;
    end
    return r;
  endfunction

  // true when the lookup touches only table words that were written
  function automatic bit read_is_defined(logic [15:0] s);
    int idx;
    int off;
    idx = s[15:3];
    off = idx * 8;
    if (idx == 0 || s[2] || off + 7 > gen_limit || idx >= sdd_pkg::TABLE_ENTRIES) begin
      return 1'b1;
    end
    if (!gen_written[idx]) begin
      return 1'b0;
    end
    if (is_system_pair(gen_word[idx]) && off + 15 <= gen_limit &&
        idx + 1 < sdd_pkg::TABLE_ENTRIES) begin
      return gen_written[idx + 1];
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] random_descriptor();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: begin
        w[44] = 1'b0;
        w[43:40] = sdd_pkg::TYPE_LDT;
      end
      1: begin
        w[44] = 1'b0;
        w[43:40] = sdd_pkg::TYPE_TSS_AVL;
      end
      2: begin
        w[44] = 1'b0;
        w[43:40] = sdd_pkg::TYPE_TSS_BUSY;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] pick_selector();
    logic [15:0] s;
    int          top;
    top = gen_limit >> 3;
    if (top > sdd_pkg::TABLE_ENTRIES) begin
      top = sdd_pkg::TABLE_ENTRIES;
    end
    do begin
      s = 16'($urandom);
      if ($urandom_range(0, 99) < 80) begin
        s[15:3] = 13'($urandom_range(0, top));
        s[2] = ($urandom_range(0, 9) == 0);
      end
    end while (!read_is_defined(s));
    return s;
  endfunction

  task automatic push_write(logic [5:0] idx, logic [63:0] w);
    seg_item_t it;
    it.cmd = sdd_pkg::CMD_WRITE;
    it.index = idx;
    it.word = w;
    it.sel = 16'($urandom);
    it.drain_first = 1'b0;
    gen_word[idx] = w;
    gen_written[idx] = 1'b1;
    item_q.push_back(it);
  endtask

  task automatic push_lookup(logic [15:0] s, bit drain);
    seg_item_t it;
    it.cmd = sdd_pkg::CMD_LOOKUP;
    it.index = 6'($urandom);
    it.word = {$urandom, $urandom};
    it.sel = s;
    it.drain_first = drain;
    item_q.push_back(it);
  endtask

  task automatic fill_random(int count);
    int top;
    top = gen_limit >> 3;
    if (top > sdd_pkg::TABLE_ENTRIES - 1) begin
      top = sdd_pkg::TABLE_ENTRIES - 1;
    end
    // open with a run of writes so the lookups land on real descriptors
    for (int k = 0; k < count; k++) begin
      if (k < 12 || $urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 99) < 75) begin
          push_write(6'($urandom_range(0, top)), random_descriptor());
        end else begin
          push_write(6'($urandom), random_descriptor());
        end
      end else begin
        push_lookup(pick_selector(), $urandom_range(0, 49) == 0);
      end
    end
  endtask

  task automatic fill_directed();
    push_write(6'd0,  64'h5555_AAAA_5555_AAAA);
    push_write(6'd1,  64'h00CF_9A00_0000_FFFF);
    push_write(6'd2,  64'h1200_8234_5678_00FF);
    push_write(6'd3,  64'hFFFF_FFFF_8765_4321);
    push_write(6'd4,  64'hAB88_0BCD_EF01_0067);
    push_write(6'd5,  64'h0000_0000_CAFE_F00D);
    push_write(6'd6,  64'hFFFF_FFFF_FFFF_FFFF);
    push_write(6'd7,  64'h0000_0000_0000_0000);
    push_write(6'd63, 64'h00A0_E900_1000_2000);
    push_lookup(16'h0000, 1'b1);
    push_lookup(16'h0003, 1'b0);
    push_lookup(16'h000C, 1'b0);
    push_lookup(16'h0008, 1'b0);
    push_lookup(16'h000B, 1'b0);
    push_lookup(16'h0010, 1'b0);
    push_lookup(16'h0020, 1'b0);
    push_lookup(16'h0030, 1'b0);
    push_lookup(16'h01F8, 1'b0);
    push_lookup(16'h0038, 1'b0);
    push_lookup(16'hFFFF, 1'b0);
    push_lookup(16'hFFF8, 1'b0);
    push_lookup(16'h0200, 1'b0);
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (item_q.size() != 0 || in_valid || n_accepted != n_received);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_table_limit(logic [15:0] lim);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    shadow_limit = lim;
    gen_limit = lim;
    n_settings++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // driver: presents queued items in bursts
  always @(posedge clk) begin
    bit took;
    bit hold;
    int outstanding;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      took = in_valid && in_ready;
      hold = in_valid && !in_ready;
      if (took) begin
        expected_segments.push_back(decode_item(item_q.pop_front()));
        n_accepted <= n_accepted + 1;
      end
      outstanding = n_accepted - n_received + (took ? 1 : 0);
      if (hold) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0 && !(item_q[0].drain_first && outstanding != 0)) begin
        in_valid <= 1'b1;
        cmd <= item_q[0].cmd;
        entry_index <= item_q[0].index;
        entry_word <= item_q[0].word;
        seg_selector <= item_q[0].sel;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // monitor: checks each result transfer, stalls on its own pattern
  always @(posedge clk) begin
    seg_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_received <= n_received + 1;
        if (expected_segments.size() == 0) begin
          $error("result transfer with no pending expectation");
          mismatch_count++;
        end else begin
          want = expected_segments.pop_front();
          check_field("seg_base", want.base, seg_base);
          check_field("seg_limit", 64'(want.limit), 64'(seg_limit));
          check_field("access_rights", 64'(want.ar), 64'(access_rights));
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (rx_tick % 5 == 0);
        default:   out_ready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  initial begin
    logic [15:0] limits [$];
    for (int k = 0; k < sdd_pkg::TABLE_ENTRIES; k++) begin
      gen_written[k] = 1'b0;
      shadow_table[k] = '0;
    end
    limits = '{16'h0000, 16'h01FF, 16'h01F7, 16'h000F,
               16'($urandom_range(2, 70) * 8 + 7), 16'($urandom), 16'hFFFF};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_table_limit(16'hFFFF);
    fill_directed();
    fill_random(200);
    foreach (limits[k]) begin
      set_table_limit(limits[k]);
      fill_random(215);
    end
    wait_idle();
    if (expected_segments.size() != 0) begin
      $error("%0d expected results never arrived", expected_segments.size());
      mismatch_count++;
    end
    $display("covered %0d table writes and %0d lookups over %0d limit settings",
             n_writes, n_lookups, n_settings);
    $display("lookups: %0d rejected, %0d with upper base word, %0d not present",
             n_rejected, n_upper, n_absent);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/sdd_pkg.sv
rtl/sdd_table_ram.sv
rtl/sdd_lookup_ctrl.sv
rtl/segment_descriptor_decoder_top.sv
rtl/sdd_checker.sv
sim/testbench.sv
